>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the coordinate transform RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pct_pkg.sv
// ---------------------------------------------------------------------------
// pct_pkg
// Types, codes and term sequencing for the polynomial coordinate transform.
// ---------------------------------------------------------------------------
package pct_pkg;

  localparam int MAX_ORDER = 3;
  localparam int COORD_W   = 32;
  localparam int COEF_W    = 48;
  localparam int TERM_W    = 4;
  localparam int CNT_W     = 5;
  localparam int MEM_AW    = 5;
  localparam int CFG_W     = 3;

  localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sd65536;

  localparam logic [2:0] METHOD_NONE     = 3'd0;
  localparam logic [2:0] METHOD_AFFINE   = 3'd1;
  localparam logic [2:0] METHOD_BILINEAR = 3'd2;
  localparam logic [2:0] METHOD_SECOND   = 3'd3;
  localparam logic [2:0] METHOD_THIRD    = 3'd4;
  localparam logic [2:0] METHOD_GENERAL  = 3'd5;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  localparam logic CFG_METHOD = 1'b0;
  localparam logic CFG_ORDER  = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic                      inverse;
    logic                      axis;
    logic [TERM_W-1:0]         term;
    logic signed [COEF_W-1:0]  coefficient;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      ok;
  } result_t;

  typedef enum logic [2:0] {
    SRC_ONE, SRC_X, SRC_Y, SRC_X2, SRC_Y2, SRC_X3, SRC_Y3
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_X2, DST_Y2, DST_X3, DST_Y3
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    dst_t dst;
  } term_op_t;

  function automatic logic [1:0] clamp_order(logic [1:0] order);
    logic [1:0] n;
    if (int'(order) > MAX_ORDER) begin
      n = 2'(MAX_ORDER);
    end else begin
      n = order;
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] term_count(logic [2:0] method, logic [1:0] order);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    case (method)
      METHOD_AFFINE:   cnt = 5'd3;
      METHOD_BILINEAR: cnt = 5'd4;
      METHOD_SECOND:   cnt = 5'd6;
      METHOD_THIRD:    cnt = 5'd9;
      METHOD_GENERAL: begin
        case (clamp_order(order))
          2'd1:    cnt = 5'd4;
          2'd2:    cnt = 5'd9;
          2'd3:    cnt = 5'd16;
          default: cnt = '0;
        endcase
      end
      default: cnt = '0;
    endcase
    return cnt;
  endfunction

  function automatic src_t xpow(logic [1:0] k);
    src_t s;
    case (k)
      2'd1:    s = SRC_X;
      2'd2:    s = SRC_X2;
      2'd3:    s = SRC_X3;
      default: s = SRC_ONE;
    endcase
    return s;
  endfunction

  function automatic src_t ypow(logic [1:0] j);
    src_t s;
    case (j)
      2'd1:    s = SRC_Y;
      2'd2:    s = SRC_Y2;
      2'd3:    s = SRC_Y3;
      default: s = SRC_ONE;
    endcase
    return s;
  endfunction

  // Each term is a*b in Q16.16; plain terms use b = 1.0.
  function automatic term_op_t term_op(logic [2:0] method, logic [1:0] order,
                                       logic [TERM_W-1:0] idx);
    term_op_t   o;
    logic [1:0] n;
    logic [3:0] lim;
    logic [3:0] m;
    logic [1:0] j;
    logic [1:0] k;
    o   = '{a: SRC_ONE, b: SRC_ONE, dst: DST_NONE};
    n   = clamp_order(order);
    lim = 4'({n, 1'b0});
    m   = idx - lim - 4'd1;
    j   = 2'd1;
    k   = 2'd1;
    case (method) inside
      METHOD_AFFINE, METHOD_BILINEAR, METHOD_SECOND, METHOD_THIRD: begin
        case (idx)
          4'd1:    o.a = SRC_X;
          4'd2:    o.a = SRC_Y;
          4'd3:    o = '{a: SRC_X,  b: SRC_Y,  dst: DST_NONE};
          4'd4:    o = '{a: SRC_X,  b: SRC_X,  dst: DST_X2};
          4'd5:    o = '{a: SRC_Y,  b: SRC_Y,  dst: DST_Y2};
          4'd6:    o = '{a: SRC_X2, b: SRC_Y2, dst: DST_NONE};
          4'd7:    o = '{a: SRC_X2, b: SRC_X,  dst: DST_NONE};
          4'd8:    o = '{a: SRC_Y2, b: SRC_Y,  dst: DST_NONE};
          default: o = '{a: SRC_ONE, b: SRC_ONE, dst: DST_NONE};
        endcase
      end
      METHOD_GENERAL: begin
        if (idx == '0) begin
          o = '{a: SRC_ONE, b: SRC_ONE, dst: DST_NONE};
        end else if (idx <= lim) begin
          j = 2'(({1'b0, idx} + 5'd1) >> 1);
          case (j)
            2'd2:    o = idx[0] ? '{a: SRC_X,  b: SRC_X, dst: DST_X2}
                                : '{a: SRC_Y,  b: SRC_Y, dst: DST_Y2};
            2'd3:    o = idx[0] ? '{a: SRC_X2, b: SRC_X, dst: DST_X3}
                                : '{a: SRC_Y2, b: SRC_Y, dst: DST_Y3};
            default: o = idx[0] ? '{a: SRC_X,  b: SRC_ONE, dst: DST_NONE}
                                : '{a: SRC_Y,  b: SRC_ONE, dst: DST_NONE};
          endcase
        end else begin
          case (n)
            2'd2: begin
              j = {1'b0, m[1]} + 2'd1;
              k = {1'b0, m[0]} + 2'd1;
            end
            2'd3: begin
              case (m)
                4'd0:    begin j = 2'd1; k = 2'd1; end
                4'd1:    begin j = 2'd1; k = 2'd2; end
                4'd2:    begin j = 2'd1; k = 2'd3; end
                4'd3:    begin j = 2'd2; k = 2'd1; end
                4'd4:    begin j = 2'd2; k = 2'd2; end
                4'd5:    begin j = 2'd2; k = 2'd3; end
                4'd6:    begin j = 2'd3; k = 2'd1; end
                4'd7:    begin j = 2'd3; k = 2'd2; end
                4'd8:    begin j = 2'd3; k = 2'd3; end
                default: begin j = 2'd1; k = 2'd1; end
              endcase
            end
            default: begin
              j = 2'd1;
              k = 2'd1;
            end
          endcase
          o = '{a: ypow(j), b: xpow(k), dst: DST_NONE};
        end
      end
      default: o = '{a: SRC_ONE, b: SRC_ONE, dst: DST_NONE};
    endcase
    return o;
  endfunction

endpackage

>>> rtl/pct_term_gen.sv
// ---------------------------------------------------------------------------
// pct_term_gen
// Term generator: one Q16.16 multiply per term with power registers.
// ---------------------------------------------------------------------------
module pct_term_gen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               issue,
  input  pct_pkg::term_op_t                  op,
  input  logic signed [pct_pkg::COORD_W-1:0] x,
  input  logic signed [pct_pkg::COORD_W-1:0] y,
  output logic signed [pct_pkg::COORD_W-1:0] term
);
  import pct_pkg::*;

  logic signed [2*COORD_W-1:0] prod;
  dst_t                        dst1;
  logic signed [COORD_W-1:0]   x2, y2, x3, y3;
  logic signed [COORD_W-1:0]   x2_cur, y2_cur, x3_cur, y3_cur;
  logic signed [COORD_W-1:0]   fwd;
  logic signed [COORD_W-1:0]   a_val, b_val;
  logic signed [COEF_W-1:0]    shifted;

  assign shifted = prod[2*COORD_W-1:16];

  always_comb begin
    if (shifted[COEF_W-1:COORD_W-1] == '0 || shifted[COEF_W-1:COORD_W-1] == '1) begin
      fwd = shifted[COORD_W-1:0];
    end else if (shifted[COEF_W-1]) begin
      fwd = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      fwd = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // forward a power that is still in the saturate stage
  assign x2_cur = (dst1 == DST_X2) ? fwd : x2;
  assign y2_cur = (dst1 == DST_Y2) ? fwd : y2;
  assign x3_cur = (dst1 == DST_X3) ? fwd : x3;
  assign y3_cur = (dst1 == DST_Y3) ? fwd : y3;

  always_comb begin
    case (op.a)
      SRC_X:   a_val = x;
      SRC_Y:   a_val = y;
      SRC_X2:  a_val = x2_cur;
      SRC_Y2:  a_val = y2_cur;
      SRC_X3:  a_val = x3_cur;
      SRC_Y3:  a_val = y3_cur;
      default: a_val = ONE_Q16;
    endcase
    case (op.b)
      SRC_X:   b_val = x;
      SRC_Y:   b_val = y;
      SRC_X2:  b_val = x2_cur;
      SRC_Y2:  b_val = y2_cur;
      SRC_X3:  b_val = x3_cur;
      SRC_Y3:  b_val = y3_cur;
      default: b_val = ONE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst1 <= DST_NONE;
    end else begin
      dst1 <= issue ? op.dst : DST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_val * b_val;
    term <= fwd;
    case (dst1)
      DST_X2:  x2 <= fwd;
      DST_Y2:  y2 <= fwd;
      DST_X3:  x3 <= fwd;
      DST_Y3:  y3 <= fwd;
      default: ;
    endcase
  end

endmodule

>>> rtl/pct_coef_mem.sv
// ---------------------------------------------------------------------------
// pct_coef_mem
// Coefficient tables for the x and y results, one synchronous RAM each.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pct_coef_mem (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic                              wsel,
  input  logic [pct_pkg::MEM_AW-1:0]        waddr,
  input  logic signed [pct_pkg::COEF_W-1:0] wdata,
  input  logic                              re,
  input  logic [pct_pkg::MEM_AW-1:0]        raddr,
  output logic signed [pct_pkg::COEF_W-1:0] rdata_x,
  output logic signed [pct_pkg::COEF_W-1:0] rdata_y
);
  import pct_pkg::*;

  localparam int DEPTH = 1 << MEM_AW;

  logic signed [COEF_W-1:0] mem_x [DEPTH];
  logic signed [COEF_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we && !wsel) begin
      mem_x[waddr] <= wdata;
    end
    if (re) begin
      rdata_x <= mem_x[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we && wsel) begin
      mem_y[waddr] <= wdata;
    end
    if (re) begin
      rdata_y <= mem_y[raddr];
    end
  end

  `PCT_ASSERT_IMP(a_no_load_during_read, clk, rst, we, !re, "coefficient load during transform read")

endmodule

>>> rtl/pct_mac.sv
// ---------------------------------------------------------------------------
// pct_mac
// Coefficient times term multiply-accumulate for one result axis.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pct_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               valid,
  input  logic signed [pct_pkg::COEF_W-1:0]  coef,
  input  logic signed [pct_pkg::COORD_W-1:0] term,
  output logic                               busy,
  output logic signed [pct_pkg::COORD_W-1:0] sum
);
  import pct_pkg::*;

  localparam int LO_W   = 16;
  localparam int HI_W   = COEF_W - LO_W;
  localparam int PH_W   = HI_W + COORD_W;
  localparam int PL_W   = LO_W + 1 + COORD_W;
  localparam int FULL_W = COEF_W + COORD_W;
  localparam int ACC_W  = COEF_W + 4;

  logic                     va, vb;
  logic signed [PH_W-1:0]   ph;
  logic signed [PL_W-1:0]   pl;
  logic signed [FULL_W-1:0] full;
  logic signed [COEF_W-1:0] part;
  logic signed [ACC_W-1:0]  acc;

  // c*t rebuilt from the two partial products; part keeps floor(c*t / 2^32)
  assign full = (FULL_W'(ph) <<< LO_W) + FULL_W'(pl);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= valid;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    ph   <= $signed(coef[COEF_W-1:LO_W]) * term;
    pl   <= $signed({1'b0, coef[LO_W-1:0]}) * term;
    part <= full[FULL_W-1:2*LO_W];
    if (clear) begin
      acc <= '0;
    end else if (vb) begin
      acc <= acc + ACC_W'(part);
    end
  end

  assign busy = va || vb;

  always_comb begin
    if (acc[ACC_W-1:COORD_W-1] == '0 || acc[ACC_W-1:COORD_W-1] == '1) begin
      sum = acc[COORD_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sum = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  `PCT_ASSERT_IMP(a_clear_when_idle, clk, rst, clear, !busy && !valid, "accumulator cleared mid-sum")

endmodule

>>> rtl/polynomial_coordinate_transform.sv
// Load item: written to the coefficient RAM at the transfer edge, next item the cycle after.
// Transform item with N terms (3 to 16): terms issue in RUN; once the MACs drain, FINISH registers the result.
// One point at a time: items are taken only in IDLE; a single term multiplier and one MAC per axis serve all terms.
// Method none or reserved, or general with order 0: goes straight to FINISH, input echoed with ok low.
// Reset clears control state and config (method 0, order 1); coefficient RAM stays unset.
// ---------------------------------------------------------------------------
// polynomial_coordinate_transform
// Fixed-point 2-D polynomial warp with loadable forward and inverse coefficients.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module polynomial_coordinate_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  pct_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output pct_pkg::result_t             result,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pct_pkg::CFG_W-1:0]    cfg_data
);
  import pct_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t                    state;
  logic [2:0]                method;
  logic [1:0]                order;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          nterm;
  logic [TERM_W-1:0]         t1;
  logic                      inv_q;
  logic                      echo;
  logic                      pv1, pv2;
  logic signed [COORD_W-1:0] x_q, y_q;

  logic                      accept, load, start, issue;
  logic [CNT_W-1:0]          count_now;
  term_op_t                  op;
  logic signed [COORD_W-1:0] term;
  logic signed [COEF_W-1:0]  coef_x, coef_y;
  logic signed [COORD_W-1:0] sum_x, sum_y;
  logic                      busy_x, busy_y;

  assign item_ready = (state == IDLE);
  assign accept     = item_valid && item_ready;
  assign load       = accept && (item.operation == OP_LOAD);
  assign start      = accept && (item.operation == OP_TRANSFORM);
  assign issue      = (state == RUN) && (cnt < nterm);
  assign count_now  = term_count(method, order);
  assign op         = term_op(method, order, cnt[TERM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= METHOD_NONE;
      order  <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_METHOD: method <= cfg_data;
        CFG_ORDER:  order  <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      cnt          <= '0;
      nterm        <= '0;
      echo         <= 1'b0;
      pv1          <= 1'b0;
      pv2          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pv1 <= issue;
      pv2 <= pv1;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (result_valid && result_ready && state != FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            cnt   <= '0;
            nterm <= count_now;
            echo  <= (count_now == '0);
            state <= (count_now == '0) ? FINISH : RUN;
          end
        end
        RUN: begin
          if (!issue && !pv1 && !pv2 && !busy_x && !busy_y) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result.x_out <= echo ? x_q : sum_x;
            result.y_out <= echo ? y_q : sum_y;
            result.ok    <= !echo;
            state        <= IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q   <= item.x_in;
      y_q   <= item.y_in;
      inv_q <= item.inverse;
    end
    t1 <= cnt[TERM_W-1:0];
  end

  pct_term_gen u_term_gen (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .op    (op),
    .x     (x_q),
    .y     (y_q),
    .term  (term)
  );

  pct_coef_mem u_coef_mem (
    .clk     (clk),
    .rst     (rst),
    .we      (load),
    .wsel    (item.axis),
    .waddr   ({item.inverse, item.term}),
    .wdata   (item.coefficient),
    .re      (pv1),
    .raddr   ({inv_q, t1}),
    .rdata_x (coef_x),
    .rdata_y (coef_y)
  );

  pct_mac u_mac_x (
    .clk   (clk),
    .rst   (rst),
    .clear (start),
    .valid (pv2),
    .coef  (coef_x),
    .term  (term),
    .busy  (busy_x),
    .sum   (sum_x)
  );

  pct_mac u_mac_y (
    .clk   (clk),
    .rst   (rst),
    .clear (start),
    .valid (pv2),
    .coef  (coef_y),
    .term  (term),
    .busy  (busy_y),
    .sum   (sum_y)
  );

  `PCT_ASSERT_IMP(a_finish_drained, clk, rst, state == FINISH, !pv1 && !pv2 && !busy_x && !busy_y, "result taken before pipeline drained")
  `PCT_ASSERT_NXT(a_load_stays_idle, clk, rst, load, state == IDLE && !pv1, "coefficient load started the engine")

endmodule

>>> test/pct_warp_checker.sv
// ---------------------------------------------------------------------------
// pct_warp_checker
// Watches the item, result and register ports of the polynomial coordinate
// transform. It keeps its own copy of the coefficient table and the method
// and order registers, predicts the point that each transform transfer must
// produce, and compares each result transfer, field by field, with the oldest
// prediction. It reports the mismatch count and the count of points still due.
// ---------------------------------------------------------------------------
module pct_warp_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  pct_pkg::item_t            item,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  pct_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [pct_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;

  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic [2:0]               method_q;
  logic [1:0]               order_q;
  logic signed [COEF_W-1:0] coef_table [64];
  result_t                  expected_points [$];

  function automatic longint sat32(longint v);
    longint r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint coef_product(logic signed [COEF_W-1:0] c, longint t);
    logic signed [95:0] cw;
    logic signed [95:0] tw;
    logic signed [95:0] p;
    cw = c;
    tw = t;
    p  = cw * tw;
    return longint'(p >>> 32);
  endfunction

  function automatic result_t warp_point(item_t it);
    longint  tv [16];
    longint  xp [4];
    longint  yp [4];
    longint  x;
    longint  y;
    longint  acc_x;
    longint  acc_y;
    int      nterms;
    int      n;
    int      i;
    int      j;
    int      k;
    int      t;
    result_t r;
    x      = longint'(it.x_in);
    y      = longint'(it.y_in);
    tv[0]  = longint'(ONE_Q16);
    nterms = 0;
    case (method_q)
      METHOD_AFFINE: begin
        tv[1]  = x;
        tv[2]  = y;
        nterms = 3;
      end
      METHOD_BILINEAR: begin
        tv[1]  = x;
        tv[2]  = y;
        tv[3]  = qmul(x, y);
        nterms = 4;
      end
      METHOD_SECOND, METHOD_THIRD: begin
        tv[1]  = x;
        tv[2]  = y;
        tv[3]  = qmul(x, y);
        tv[4]  = qmul(x, x);
        tv[5]  = qmul(y, y);
        nterms = 6;
        if (method_q == METHOD_THIRD) begin
          tv[6]  = qmul(tv[4], tv[5]);
          tv[7]  = qmul(tv[4], x);
          tv[8]  = qmul(tv[5], y);
          nterms = 9;
        end
      end
      METHOD_GENERAL: begin
        n = int'(order_q);
        if (n > MAX_ORDER) begin
          n = MAX_ORDER;
        end
        xp[0] = longint'(ONE_Q16);
        yp[0] = longint'(ONE_Q16);
        i = 1;
        for (j = 1; j <= n; j++) begin
          xp[j]   = qmul(xp[j-1], x);
          yp[j]   = qmul(yp[j-1], y);
          tv[i]   = xp[j];
          tv[i+1] = yp[j];
          i += 2;
        end
        for (j = 1; j <= n; j++) begin
          for (k = 1; k <= n; k++) begin
            tv[i] = qmul(yp[j], xp[k]);
            i++;
          end
        end
        nterms = (n == 0) ? 0 : i;
      end
      default: nterms = 0;
    endcase

    if (nterms == 0) begin
      r.x_out = it.x_in;
      r.y_out = it.y_in;
      r.ok    = 1'b0;
    end else begin
      acc_x = 0;
      acc_y = 0;
      for (t = 0; t < nterms; t++) begin
        acc_x += coef_product(coef_table[{it.inverse, 1'b0, 4'(t)}], tv[t]);
        acc_y += coef_product(coef_table[{it.inverse, 1'b1, 4'(t)}], tv[t]);
      end
      r.x_out = 32'(sat32(acc_x));
      r.y_out = 32'(sat32(acc_y));
      r.ok    = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t expected;
    if (rst) begin
      method_q   = METHOD_NONE;
      order_q    = 2'd1;
      mismatches = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_METHOD) begin
          method_q = cfg_data;
        end else begin
          order_q = cfg_data[1:0];
        end
      end
      if (result_valid && result_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: result with none due, expected none, actual x_out %0d y_out %0d ok %0b",
                   $time, result.x_out, result.y_out, result.ok);
        end else begin
          expected = expected_points.pop_front();
          if (result.x_out !== expected.x_out) begin
            mismatches++;
            $display("%0t: x_out mismatch, expected %0d, actual %0d",
                     $time, expected.x_out, result.x_out);
          end
          if (result.y_out !== expected.y_out) begin
            mismatches++;
            $display("%0t: y_out mismatch, expected %0d, actual %0d",
                     $time, expected.y_out, result.y_out);
          end
          if (result.ok !== expected.ok) begin
            mismatches++;
            $display("%0t: ok mismatch, expected %0b, actual %0b",
                     $time, expected.ok, result.ok);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (item.operation == OP_LOAD) begin
          coef_table[{item.inverse, item.axis, item.term}] = item.coefficient;
        end else begin
          expected_points.push_back(warp_point(item));
        end
      end
    end
    outstanding = expected_points.size();
  end

endmodule

>>> test/tb_polynomial_coordinate_transform.sv
// ---------------------------------------------------------------------------
// tb_polynomial_coordinate_transform
// Drives coefficient loads and point transforms into the transform block in
// random bursts, with a result side that stalls on its own pattern and once
// holds off long enough to back up the input. Register settings change only
// while the block is idle. A checker beside the block predicts every point.
// ---------------------------------------------------------------------------
module tb_polynomial_coordinate_transform;
  timeunit 1ns;
  timeprecision 1ps;

  import pct_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 125;
  localparam int HOLD_SEGMENT = 2;
  localparam int DENSE_ITEMS  = 40;
  localparam int IDLE_PAD     = 4;
  localparam int END_PAD      = 40;
  localparam int DIR_SETTINGS = 11;

  localparam logic [2:0] METHOD_RSVD6 = 3'd6;
  localparam logic [2:0] METHOD_RSVD7 = 3'd7;

  localparam logic signed [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  item_t            item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result;
  logic             cfg_we       = 1'b0;
  logic             cfg_index    = CFG_METHOD;
  logic [CFG_W-1:0] cfg_data     = '0;

  int mismatches;
  int outstanding;
  int cycles        = 0;
  int hold_requests = 0;
  int burst_left    = 0;
  bit dense         = 1'b0;

  polynomial_coordinate_transform u_top (.*);

  pct_warp_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("polynomial_coordinate_transform regression: fail");
      $finish;
    end
  end

  initial begin : receiver
    int mode;
    int seg_left;
    int phase;
    int hold_seen;
    mode      = 0;
    seg_left  = 0;
    phase     = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      phase++;
      case (mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom_range(0, 1));
        2:       result_ready <= ($urandom_range(0, 3) == 0);
        default: result_ready <= (phase % 3 != 0);
      endcase
    end
  end

  function automatic logic signed [COEF_W-1:0] random_coef();
    logic signed [COEF_W-1:0] c;
    c = COEF_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      1:       c = c >>> 12;
      2:       c = c >>> 18;
      3:       c = c >>> 24;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      1:       v = v >>> 8;
      2:       v = v >>> 12;
      3:       v = v >>> 14;
      default: ;
    endcase
    return v;
  endfunction

  function automatic item_t random_item(logic op);
    item_t it;
    it.operation   = op;
    it.inverse     = 1'($urandom_range(0, 1));
    it.axis        = 1'($urandom_range(0, 1));
    it.term        = TERM_W'($urandom_range(0, 15));
    it.coefficient = random_coef();
    it.x_in        = random_coord();
    it.y_in        = random_coord();
    return it;
  endfunction

  task automatic offer(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (!dense) begin
      if (burst_left == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle(input int extra);
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [2:0] method, input logic [1:0] order);
    settle(IDLE_PAD);
    write_reg(CFG_METHOD, method);
    write_reg(CFG_ORDER, {1'b0, order});
  endtask

  task automatic fill_table(input bit with_extremes);
    item_t it;
    int    e;
    for (e = 0; e < 64; e++) begin
      it = random_item(OP_LOAD);
      {it.inverse, it.axis, it.term} = 6'(e);
      if (with_extremes && e == 0) begin
        it.coefficient = COEF_MAX;
      end else if (with_extremes && e == 16) begin
        it.coefficient = COEF_MIN;
      end
      offer(it);
    end
  endtask

  initial begin : stimulus
    item_t      it;
    logic [2:0] dir_method [DIR_SETTINGS];
    logic [1:0] dir_order [DIR_SETTINGS];
    logic [2:0] m;
    int         s;
    int         p;
    int         seg;
    int         n;
    dir_method = '{METHOD_AFFINE, METHOD_BILINEAR, METHOD_SECOND, METHOD_THIRD,
                   METHOD_GENERAL, METHOD_GENERAL, METHOD_GENERAL, METHOD_GENERAL,
                   METHOD_RSVD6, METHOD_RSVD7, METHOD_NONE};
    dir_order  = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd0, 2'd2};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    it = random_item(OP_TRANSFORM);
    it.inverse = 1'b0;
    it.x_in    = COORD_MAX;
    it.y_in    = COORD_MIN;
    offer(it);
    it = random_item(OP_TRANSFORM);
    it.inverse = 1'b1;
    it.x_in    = COORD_MIN;
    it.y_in    = COORD_MAX;
    offer(it);

    fill_table(1'b1);

    for (s = 0; s < DIR_SETTINGS; s++) begin
      configure(dir_method[s], dir_order[s]);
      for (p = 0; p < 2; p++) begin
        it = random_item(OP_TRANSFORM);
        it.inverse = p[0];
        case ((s * 2 + p) % 4)
          0: begin
            it.x_in = COORD_MAX;
            it.y_in = COORD_MAX;
          end
          1: begin
            it.x_in = COORD_MIN;
            it.y_in = COORD_MIN;
          end
          2: begin
            it.x_in = COORD_MAX;
            it.y_in = COORD_MIN;
          end
          default: begin
            it.x_in = '0;
            it.y_in = '0;
          end
        endcase
        offer(it);
      end
    end

    fill_table(1'b0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 0) begin
        configure(METHOD_GENERAL, 2'd3);
      end else begin
        m = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(METHOD_AFFINE, METHOD_GENERAL));
        configure(m, 2'($urandom_range(0, 3)));
      end
      if (seg == HOLD_SEGMENT) begin
        hold_requests <= hold_requests + 1;
        dense = 1'b1;
      end
      for (n = 0; n < SEG_ITEMS; n++) begin
        if (dense && n == DENSE_ITEMS) begin
          dense = 1'b0;
        end
        it = random_item(($urandom_range(0, 9) < 3) ? OP_LOAD : OP_TRANSFORM);
        offer(it);
      end
    end

    settle(END_PAD);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("polynomial_coordinate_transform regression: pass");
    end else begin
      $display("polynomial_coordinate_transform regression: fail");
    end
    $finish;
  end

endmodule

>>> polynomial_coordinate_transform.f
+incdir+rtl
rtl/pct_pkg.sv
rtl/pct_term_gen.sv
rtl/pct_coef_mem.sv
rtl/pct_mac.sv
rtl/polynomial_coordinate_transform.sv
test/pct_warp_checker.sv
test/tb_polynomial_coordinate_transform.sv
